FILE: src/tprm_pkg.sv
// ----------------------------------------------------------------------------
// tprm_pkg: shared types and constants of the top-k precision/recall meter
// Holds the request and status codes, size limits, field widths, FSM states and the cell command.
// ----------------------------------------------------------------------------
`default_nettype none
package tprm_pkg;

  typedef enum logic [1:0] {
    REQ_SCORE = 2'd0,
    REQ_LABEL = 2'd1,
    REQ_EOS   = 2'd2,
    REQ_EOB   = 2'd3
  } req_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOLABEL = 2'd1;
  localparam logic [1:0] ST_FEWCLS  = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  localparam int MAX_K       = 16;
  localparam int CLASSES     = 1024;
  localparam int MAX_LABELS  = 16;
  localparam int MAX_SAMPLES = 1024;
  localparam int LBL_W       = $clog2(MAX_LABELS + 1);

  localparam int SCORE_W = 32;
  localparam int CLASS_W = 10;
  localparam int Q_W     = 17;
  localparam int SUM_W   = 27;
  localparam int CNT_W   = 11;

  localparam logic [Q_W-1:0] Q_ONE = 17'd65536;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_SAMPLE,
    S_DIV_BATCH,
    S_OUT
  } state_t;

  // Command broadcast to every ranking cell.
  typedef struct packed {
    logic                    ins;    // insert a score
    logic                    clr;    // drop all entries
    logic signed [SCORE_W-1:0] score;
    logic [CLASS_W-1:0]      cls;
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: src/tprm_cell.sv
// ----------------------------------------------------------------------------
// tprm_cell: one slot of the ranked list
// Holds a score and class; on insert keeps, takes the new item, or takes the
// left neighbor's entry so the list shifts right behind the insertion point.
// ----------------------------------------------------------------------------
`default_nettype none
module tprm_cell (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire tprm_pkg::cell_cmd_t   cmd,
  input  wire logic                  en,        // slot index below effective k
  input  wire logic                  left_win,  // new score ranks before left
  input  wire logic                  left_valid,
  input  wire logic signed [31:0]    left_score,
  input  wire logic [9:0]            left_cls,
  output logic                       valid,
  output logic signed [31:0]         score_q,
  output logic [9:0]                 cls_q,
  output logic                       win        // new score ranks before this
);
  // A held entry loses to the new score unless strictly larger.
  assign win = !valid || !(score_q > cmd.score);

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      valid <= 1'b0;
    end else if (cmd.ins) begin
      if (!en) begin
        valid <= 1'b0;
      end else if (win && !left_win) begin
        valid   <= 1'b1;
        score_q <= cmd.score;
        cls_q   <= cmd.cls;
      end else if (win && left_win) begin
        valid   <= left_valid;
        score_q <= left_score;
        cls_q   <= left_cls;
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/tprm_divider.sv
// ----------------------------------------------------------------------------
// tprm_divider: restoring divider, one quotient bit per cycle
// Divides a 27-bit dividend by an 11-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module tprm_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [26:0] dividend,
  input  wire logic [10:0] divisor,
  output logic             busy,
  output logic [26:0]      quotient
);
  logic [4:0]  cnt;
  logic [10:0] rem;
  logic [10:0] dvs;
  logic [11:0] trial;
  logic [11:0] diff;

  always_comb trial = {rem, quotient[26]};
  always_comb diff = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 5'd0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= 5'd26;
      rem      <= 11'd0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem      <= diff[10:0];
        quotient <= {quotient[25:0], 1'b1};
      end else begin
        rem      <= trial[10:0];
        quotient <= {quotient[25:0], 1'b0};
      end
      if (cnt == 5'd0) busy <= 1'b0;
      else cnt <= cnt - 5'd1;
    end
  end
endmodule
`default_nettype wire

FILE: src/topk_precision_recall_meter.sv
// ----------------------------------------------------------------------------
// topk_precision_recall_meter: top-k precision and recall over a batch
// Ranks streamed class scores in a chain of cells, counts label hits, and
// averages per-sample precision and recall at end of batch.
// ----------------------------------------------------------------------------
//  channel | signals                               | direction
//  in      | in_valid in_ready req_type score label | request in
//  out     | out_valid out_ready precision recall   | result out
//          | status samples_seen                   |
//  cfg     | cfg_valid cfg_ready cfg_data (top_k)  | register write
//
// Scores and labels never stall the input: the cell chain compares the new
// score against every slot at once and shifts in a single step.
// A counted end of sample holds in_ready low while two divisions run on the
// shared divider, each a start, one step per quotient bit and a finish.
// A dropped end of sample does not stall the input. A non-empty end of batch
// runs the same two divisions, then the result waits in the output state for
// out_ready; an empty batch presents its result on the cycle after the request.
// Reset is synchronous; it empties the chain and clears all sums.
// ----------------------------------------------------------------------------
`default_nettype none
module topk_precision_recall_meter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [31:0] score,
  input  wire logic [9:0]         label,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [16:0]             precision,
  output logic [16:0]             recall,
  output logic [1:0]              status,
  output logic [10:0]             samples_seen,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [4:0]         cfg_data
);
  localparam int MAX_K       = tprm_pkg::MAX_K;
  localparam int CLASSES     = tprm_pkg::CLASSES;
  localparam int MAX_LABELS  = tprm_pkg::MAX_LABELS;
  localparam int MAX_SAMPLES = tprm_pkg::MAX_SAMPLES;
  localparam int LW          = tprm_pkg::LBL_W;

  tprm_pkg::state_t state, state_next;
  logic [4:0]  top_k;
  logic [6:0]  keff;
  logic [tprm_pkg::CNT_W-1:0] class_counter;
  logic [LW-1:0] label_count;
  logic [LW-1:0] hit_count;
  logic [tprm_pkg::SUM_W-1:0] precision_sum, recall_sum;
  logic [tprm_pkg::CNT_W-1:0] sample_count;
  logic [1:0]  error_code;
  logic        phase;        // 0 first division, 1 second
  logic [tprm_pkg::Q_W-1:0] p_q;

  logic acc;
  assign acc = in_valid && in_ready;
  assign in_ready  = (state == tprm_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // Clamp top_k to 1..MAX_K; zero acts as one.
  always_comb begin
    if (top_k == 5'd0) keff = 7'd1;
    else if ({2'b00, top_k} > 7'(MAX_K)) keff = 7'(MAX_K);
    else keff = {2'b00, top_k};
  end

  // cell chain
  tprm_pkg::cell_cmd_t cmd;
  logic [MAX_K-1:0] vld, win, en;
  logic signed [31:0] sc [MAX_K];
  logic [9:0] cl [MAX_K];
  logic [MAX_K-1:0] match;

  // Drop the list at every end of sample and end of batch; the hit count
  // is already final once the end-of-sample request is taken.
  always_comb begin
    cmd.ins   = acc && req_type == tprm_pkg::REQ_SCORE
                && class_counter < 11'(CLASSES);
    cmd.clr   = acc && (req_type == tprm_pkg::REQ_EOS
                        || req_type == tprm_pkg::REQ_EOB);
    cmd.score = score;
    cmd.cls   = class_counter[9:0];
  end

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    assign en[i]    = 7'(i) < keff;
    assign match[i] = vld[i] && en[i] && cl[i] == label;
    if (i == 0) begin : g_head
      tprm_cell u_cell (.clk, .rst, .cmd(cmd), .en(en[i]), .left_win(1'b0),
        .left_valid(1'b0), .left_score(32'sd0), .left_cls(10'd0),
        .valid(vld[i]), .score_q(sc[i]), .cls_q(cl[i]), .win(win[i]));
    end else begin : g_body
      tprm_cell u_cell (.clk, .rst, .cmd(cmd), .en(en[i]), .left_win(win[i-1]),
        .left_valid(vld[i-1]), .left_score(sc[i-1]), .left_cls(cl[i-1]),
        .valid(vld[i]), .score_q(sc[i]), .cls_q(cl[i]), .win(win[i]));
    end
  end

  // shared divider
  logic        dv_start, dv_busy;
  logic [26:0] dv_dend, dv_q;
  logic [10:0] dv_dsr;
  tprm_divider u_div (.clk, .rst, .start(dv_start), .dividend(dv_dend),
    .divisor(dv_dsr), .busy(dv_busy), .quotient(dv_q));

  // A sample is averaged only with labels, enough scores and room left.
  logic eos_ok;
  assign eos_ok = label_count != '0 && class_counter >= {4'd0, keff}
                  && sample_count < 11'(MAX_SAMPLES);

  always_comb begin
    state_next = state;
    unique case (state)
      tprm_pkg::S_IDLE: begin
        if (acc && req_type == tprm_pkg::REQ_EOS && eos_ok)
          state_next = tprm_pkg::S_DIV_SAMPLE;
        else if (acc && req_type == tprm_pkg::REQ_EOB)
          state_next = (sample_count == 11'd0) ? tprm_pkg::S_OUT
                                               : tprm_pkg::S_DIV_BATCH;
      end
      tprm_pkg::S_DIV_SAMPLE:
        if (!dv_busy && !dv_start && phase) state_next = tprm_pkg::S_IDLE;
      tprm_pkg::S_DIV_BATCH:
        if (!dv_busy && !dv_start && phase) state_next = tprm_pkg::S_OUT;
      tprm_pkg::S_OUT:
        if (out_ready) state_next = tprm_pkg::S_IDLE;
      default: state_next = tprm_pkg::S_IDLE;
    endcase
  end

  // Per sample: hits*65536 over k, then over labels. Per batch: each sum
  // over the sample count.
  always_comb begin
    dv_dend = '0;
    dv_dsr  = 11'd1;
    if (state == tprm_pkg::S_DIV_SAMPLE) begin
      dv_dend = {6'd0, hit_count, 16'd0};
      dv_dsr  = phase ? 11'(label_count) : {4'd0, keff};
    end else begin
      dv_dend = phase ? recall_sum : precision_sum;
      dv_dsr  = sample_count;
    end
  end

  logic started;
  assign dv_start = (state == tprm_pkg::S_DIV_SAMPLE || state == tprm_pkg::S_DIV_BATCH)
                    && !dv_busy && !started;

  // Saturate a ratio at one (repeated labels can push precision past it).
  function automatic logic [16:0] sat(input logic [26:0] v);
    sat = (v > {10'd0, tprm_pkg::Q_ONE}) ? tprm_pkg::Q_ONE : v[16:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tprm_pkg::S_IDLE;
      top_k <= 5'd1;
      class_counter <= '0; label_count <= '0; hit_count <= '0;
      precision_sum <= '0; recall_sum <= '0; sample_count <= '0;
      error_code <= tprm_pkg::ST_OK; phase <= 1'b0; started <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) top_k <= cfg_data;
      if (acc) begin
        unique case (tprm_pkg::req_t'(req_type))
          tprm_pkg::REQ_SCORE:
            if (class_counter < 11'(CLASSES)) class_counter <= class_counter + 11'd1;
          tprm_pkg::REQ_LABEL:
            if (label_count < LW'(MAX_LABELS)) begin
              label_count <= label_count + LW'(1);
              if (|match) hit_count <= hit_count + LW'(1);
            end
          tprm_pkg::REQ_EOS: begin
            // No labels is flagged before too few scores; keep the first flag.
            if (label_count == '0) begin
              if (error_code == tprm_pkg::ST_OK) error_code <= tprm_pkg::ST_NOLABEL;
            end else if (class_counter < {4'd0, keff}) begin
              if (error_code == tprm_pkg::ST_OK) error_code <= tprm_pkg::ST_FEWCLS;
            end
            class_counter <= '0;
            // Hold the counts for the divider when the sample is averaged.
            if (!eos_ok) begin
              label_count <= '0; hit_count <= '0;
            end
          end
          tprm_pkg::REQ_EOB: begin
            // Drop any unfinished sample.
            class_counter <= '0; label_count <= '0; hit_count <= '0;
            if (sample_count == 11'd0) begin
              precision <= '0; recall <= '0; status <= tprm_pkg::ST_EMPTY;
              samples_seen <= '0; out_valid <= 1'b1;
              error_code <= tprm_pkg::ST_OK;
            end
          end
          default: ;
        endcase
      end
      // division sequencing
      if (dv_start) started <= 1'b1;
      if ((state == tprm_pkg::S_DIV_SAMPLE || state == tprm_pkg::S_DIV_BATCH)
          && started && !dv_busy) begin
        started <= 1'b0;
        if (!phase) begin
          phase <= 1'b1;
          p_q   <= sat(dv_q);
        end else begin
          phase <= 1'b0;
          if (state == tprm_pkg::S_DIV_SAMPLE) begin
            precision_sum <= precision_sum + 27'(p_q);
            recall_sum    <= recall_sum + 27'(sat(dv_q));
            sample_count  <= sample_count + 11'd1;
            label_count   <= '0; hit_count <= '0;
          end else begin
            precision    <= p_q;
            recall       <= sat(dv_q);
            status       <= error_code;
            samples_seen <= sample_count;
            out_valid    <= 1'b1;
            precision_sum <= '0; recall_sum <= '0; sample_count <= '0;
            error_code <= tprm_pkg::ST_OK;
          end
        end
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // assertions
  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == tprm_pkg::S_OUT) else $error("result outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    dv_busy |-> !in_ready) else $error("accept during division");
  a_fill_prefix: assert property (@(posedge clk) disable iff (rst)
    (vld[0] == 1'b0) |-> (vld == '0)) else $error("ranked list has gap");
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= 11'(MAX_SAMPLES)) else $error("sample count overflow");
endmodule
`default_nettype wire

FILE: tb/topk_precision_recall_meter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// topk_precision_recall_meter_tb: self-checking bench of the top-k meter
// Streams directed and random batches of scores, labels and sample/batch
// markers under random backpressure, predicts every batch result with a
// behavioral ranking model, and compares each result field by field.
// ----------------------------------------------------------------------------
module topk_precision_recall_meter_tb;

  localparam int K_MAX   = 16;
  localparam int LBL_MAX = 16;
  localparam int SMP_MAX = 1024;
  localparam int CLS_MAX = 1024;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         req_type = tprm_pkg::REQ_SCORE;
  logic signed [31:0] score = '0;
  logic [9:0]         label = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [16:0]        precision;
  logic [16:0]        recall;
  logic [1:0]         status;
  logic [10:0]        samples_seen;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [4:0]         cfg_data = '0;

  topk_precision_recall_meter uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .score(score), .label(label),
    .out_valid(out_valid), .out_ready(out_ready),
    .precision(precision), .recall(recall),
    .status(status), .samples_seen(samples_seen),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [16:0] prec;
    logic [16:0] rec;
    logic [1:0]  st;
    logic [10:0] nsmp;
  } batch_res_t;

  // Predictor state: mirrors the ranking list and the batch sums.
  logic [4:0]         k_reg;
  logic signed [31:0] rank_score [K_MAX];
  logic [9:0]         rank_cls [K_MAX];
  int unsigned        fill, cls_cnt, hits, nlbl, nsmp, err_code;
  longint unsigned    psum, rsum;

  batch_res_t batch_q[$];
  int         errors;
  int         results_seen;
  int         batches_sent;
  int         send_idle_pct, recv_idle_pct;

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d (result %0d)",
             what, got, want, results_seen);
  endtask

  function automatic int unsigned eff_k();
    if (k_reg < 1) return 1;
    if (k_reg > K_MAX) return K_MAX;
    return 32'(k_reg);
  endfunction

  task automatic clear_sample();
    fill = 0; cls_cnt = 0; hits = 0; nlbl = 0;
  endtask

  task automatic clear_batch();
    clear_sample();
    psum = 0; rsum = 0; nsmp = 0; err_code = 32'(tprm_pkg::ST_OK);
  endtask

  // Advance the predictor by one accepted request.
  task automatic predict_request(input logic [1:0] rt, input logic signed [31:0] s,
                                 input logic [9:0] lb);
    int unsigned k, n, pos, last;
    longint unsigned p, r;
    batch_res_t res;
    k = eff_k();
    n = (fill < k) ? fill : k;
    case (rt)
      tprm_pkg::REQ_SCORE: begin
        if (cls_cnt < CLS_MAX) begin
          pos = 0;
          while (pos < n && rank_score[pos] > s) pos++;
          if (pos < k) begin
            last = (n < k) ? n : k - 1;
            for (int i = last; i > pos; i--) begin
              rank_score[i] = rank_score[i-1];
              rank_cls[i] = rank_cls[i-1];
            end
            rank_score[pos] = s;
            rank_cls[pos] = cls_cnt[9:0];
            fill = (n < k) ? n + 1 : k;
          end else begin
            fill = n;
          end
          cls_cnt++;
        end
      end
      tprm_pkg::REQ_LABEL: begin
        if (nlbl < LBL_MAX) begin
          for (int i = 0; i < n; i++) begin
            if (rank_cls[i] == lb) begin
              hits++;
              break;
            end
          end
          nlbl++;
        end
      end
      tprm_pkg::REQ_EOS: begin
        if (nlbl == 0) begin
          if (err_code == tprm_pkg::ST_OK) err_code = 32'(tprm_pkg::ST_NOLABEL);
        end else if (cls_cnt < k) begin
          if (err_code == tprm_pkg::ST_OK) err_code = 32'(tprm_pkg::ST_FEWCLS);
        end else if (nsmp < SMP_MAX) begin
          p = (longint'(hits) * 65536) / k;
          r = (longint'(hits) * 65536) / nlbl;
          if (p > 65536) p = 65536;
          if (r > 65536) r = 65536;
          psum += p; rsum += r; nsmp++;
        end
        clear_sample();
      end
      default: begin
        if (nsmp == 0) begin
          res = '{prec: 17'd0, rec: 17'd0, st: tprm_pkg::ST_EMPTY, nsmp: 11'd0};
        end else begin
          p = psum / nsmp;
          r = rsum / nsmp;
          if (p > 65536) p = 65536;
          if (r > 65536) r = 65536;
          res = '{prec: p[16:0], rec: r[16:0], st: err_code[1:0], nsmp: nsmp[10:0]};
        end
        batch_q = {batch_q, res};
        clear_batch();
      end
    endcase
  endtask

  // Hold the request until accepted; idle before it at the sender rate.
  task automatic send_request(input logic [1:0] rt, input logic signed [31:0] s,
                              input logic [9:0] lb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    score <= s;
    label <= lb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(rt, s, lb);
    if (rt == tprm_pkg::REQ_EOB) batches_sent++;
  endtask

  // Drop valid, then wait for all results and the end-of-sample work.
  task automatic drain();
    in_valid <= 1'b0;
    while (batch_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_top_k(input logic [4:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    k_reg = v;
  endtask

  // Receiver: drop ready at random, check each accepted result.
  always @(posedge clk) begin
    batch_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (batch_q.size() == 0) begin
        errors++;
        $display("unexpected result %0d", results_seen);
      end else begin
        want = batch_q.pop_front();
        if (precision !== want.prec) report("precision", 32'(precision), 32'(want.prec));
        if (recall !== want.rec) report("recall", 32'(recall), 32'(want.rec));
        if (status !== want.st) report("status", 32'(status), 32'(want.st));
        if (samples_seen !== want.nsmp)
          report("samples_seen", 32'(samples_seen), 32'(want.nsmp));
      end
      results_seen++;
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Random score: small values to force ties, full-range values, and extremes.
  function automatic logic signed [31:0] rand_score();
    case ($urandom_range(3))
      0: return 32'($urandom_range(3));
      1: return 32'($urandom);
      2: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(15)) - 8;
    endcase
  endfunction

  task automatic random_sample(input int unsigned max_cls);
    int unsigned ncls, nl;
    ncls = $urandom_range(max_cls);
    nl = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(1, 4);
    for (int i = 0; i < ncls; i++) send_request(tprm_pkg::REQ_SCORE, rand_score(), '0);
    for (int i = 0; i < nl; i++) begin
      if ($urandom_range(3) != 0)
        send_request(tprm_pkg::REQ_LABEL, '0, 10'($urandom_range(ncls)));
      else send_request(tprm_pkg::REQ_LABEL, '0, 10'($urandom));
    end
    if ($urandom_range(19) != 0) send_request(tprm_pkg::REQ_EOS, '0, '0);
  endtask

  // Directed rows; expected result typed in where obvious, else predicted.
  typedef struct {
    logic [1:0]         rt;
    logic signed [31:0] s;
    logic [9:0]         lb;
    logic               typed;
    batch_res_t         res;
  } row_t;

  localparam int N_ROWS = 20;
  localparam batch_res_t EMPTY_RES = '{17'd0, 17'd0, tprm_pkg::ST_EMPTY, 11'd0};
  localparam batch_res_t NONE = '{17'd0, 17'd0, tprm_pkg::ST_OK, 11'd0};
  localparam batch_res_t FULL_RES = '{17'd65536, 17'd65536, tprm_pkg::ST_OK, 11'd1};

  row_t rows [N_ROWS] = '{
    '{tprm_pkg::REQ_EOB,   0,             0,    1, EMPTY_RES},  // empty after reset
    '{tprm_pkg::REQ_SCORE, 32'sh7fffffff, 0,    0, NONE},
    '{tprm_pkg::REQ_SCORE, 32'sh80000000, 0,    0, NONE},
    '{tprm_pkg::REQ_SCORE, 32'sh7fffffff, 0,    0, NONE},  // tie: later class first
    '{tprm_pkg::REQ_LABEL, 0,             2,    0, NONE},
    '{tprm_pkg::REQ_EOS,   0,             0,    0, NONE},
    '{tprm_pkg::REQ_EOB,   0,             0,    1, FULL_RES},
    '{tprm_pkg::REQ_SCORE, 5,             0,    0, NONE},
    '{tprm_pkg::REQ_EOS,   0,             0,    0, NONE},  // sample without labels
    '{tprm_pkg::REQ_EOB,   0,             0,    1, EMPTY_RES},
    '{tprm_pkg::REQ_SCORE, -1,            0,    0, NONE},
    '{tprm_pkg::REQ_LABEL, 0,             0,    0, NONE},
    '{tprm_pkg::REQ_LABEL, 0,             0,    0, NONE},  // repeated label
    '{tprm_pkg::REQ_LABEL, 0,             1023, 0, NONE},
    '{tprm_pkg::REQ_EOS,   0,             0,    0, NONE},
    '{tprm_pkg::REQ_LABEL, 0,             3,    0, NONE},
    '{tprm_pkg::REQ_EOS,   0,             0,    0, NONE},  // no scores: too few
    '{tprm_pkg::REQ_SCORE, 1,             0,    0, NONE},
    '{tprm_pkg::REQ_LABEL, 0,             5,    0, NONE},  // unfinished sample
    '{tprm_pkg::REQ_EOB,   0,             0,    0, NONE}
  };

  initial begin
    int unsigned kset;
    errors = 0; results_seen = 0; batches_sent = 0;
    send_idle_pct = 15; recv_idle_pct = 88;
    k_reg = 5'd1;
    for (int i = 0; i < K_MAX; i++) begin
      rank_score[i] = '0;
      rank_cls[i] = '0;
    end
    clear_batch();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      send_request(rows[i].rt, rows[i].s, rows[i].lb);
      if (rows[i].typed && batch_q.size() != 0) batch_q[$] = rows[i].res;
    end
    write_top_k(5'd16);
    for (int i = 0; i < 3; i++) random_sample(20);
    send_request(tprm_pkg::REQ_EOB, '0, '0);
    write_top_k(5'd0);                              // zero acts as one
    random_sample(3);
    send_request(tprm_pkg::REQ_EOB, '0, '0);

    // Random phases: three idle patterns, several top_k settings each.
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 88; recv_idle_pct = 15; end
      if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int c = 0; c < 4; c++) begin
        kset = (c == 0) ? 31 : (c == 1) ? 1 : $urandom_range(31);
        write_top_k(kset[4:0]);
        for (int b = 0; b < 5; b++) begin
          for (int sm = $urandom_range(1, 3); sm > 0; sm--) random_sample(10);
          if (b == 3) drain();                      // sender holds for all results
          if ($urandom_range(7) == 0) send_request(tprm_pkg::REQ_SCORE, rand_score(), '0);
          send_request(tprm_pkg::REQ_EOB, '0, '0);
        end
      end
    end

    drain();
    $display("covered %0d batches and %0d results across top_k settings 0..31",
             batches_sent, results_seen);
    if (errors == 0 && batch_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
